>>> sv/adpu_pkg.sv
`default_nettype none
package adpu_pkg;
    localparam int unsigned XLEN = 64;
    localparam int unsigned NREGS = 31;
    localparam int unsigned QDEPTH = 2;
    localparam logic [2:0] OPI_ADDSUB = 3'b010;
    localparam logic [2:0] OPI_MOVW = 3'b101;
    localparam logic [3:0] OPR_MUL = 4'b1000;
    localparam logic [15:0] MOV_MASK = 16'hFFFF;
    localparam logic [4:0] ZERO_REG = 5'b11111;

    typedef enum logic [2:0] {
        K_ERR,
        K_ADDI,
        K_MOVW,
        K_MUL,
        K_ADDR,
        K_LOG
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic [31:0] ins;
    } t_dec;

    typedef struct packed {
        logic status;
        logic wrote;
        logic [4:0] dest_index;
        logic [63:0] dest_value;
        logic [3:0] flags;
    } t_res;
endpackage
`default_nettype wire

>>> sv/adpu_if.sv
`default_nettype none
interface adpu_in_if;
    logic valid;
    logic ready;
    logic cmd;
    logic [31:0] instruction;
    modport source (output valid, output cmd, output instruction, input ready);
    modport sink (input valid, input cmd, input instruction, output ready);
endinterface

interface adpu_out_if;
    logic valid;
    logic ready;
    logic status;
    logic wrote;
    logic [4:0] dest_index;
    logic [63:0] dest_value;
    logic [3:0] flags;
    modport source (output valid, output status, output wrote, output dest_index,
        output dest_value, output flags, input ready);
    modport sink (input valid, input status, input wrote, input dest_index,
        input dest_value, input flags, output ready);
endinterface
`default_nettype wire

>>> sv/adpu_front.sv
`default_nettype none
module adpu_front (
    input  wire logic              i_cmd,
    input  wire logic [31:0]       i_ins,
    output adpu_pkg::t_dec         o_dec
);
    import adpu_pkg::*;
    logic sf;
    logic [1:0] opc;
    logic [5:0] amt;
    assign sf = i_ins[31];
    assign opc = i_ins[30:29];
    assign amt = i_ins[15:10];
    always_comb begin
        o_dec.ins = i_ins;
        o_dec.kind = K_ERR;
        if (!i_cmd) begin
            if (i_ins[25:23] == OPI_ADDSUB) begin
                o_dec.kind = K_ADDI;
            end else if (i_ins[25:23] == OPI_MOVW) begin
                if (opc != 2'b01 && (sf || !i_ins[22])) o_dec.kind = K_MOVW;
            end
        end else begin
            if (i_ins[28] && i_ins[24:21] == OPR_MUL) begin
                o_dec.kind = K_MUL;
            end else if (!i_ins[28] && i_ins[24] && !i_ins[21]) begin
                if (i_ins[23:22] != 2'b11 && (sf || !amt[5])) o_dec.kind = K_ADDR;
            end else if (!i_ins[28] && !i_ins[24]) begin
                if (sf || !amt[5]) o_dec.kind = K_LOG;
            end
        end
    end
endmodule
`default_nettype wire

>>> sv/adpu_fifo.sv
`default_nettype none
module adpu_fifo #(
    parameter int unsigned DEPTH = adpu_pkg::QDEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  adpu_pkg::t_dec     i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output adpu_pkg::t_dec     o_data
);
    import adpu_pkg::*;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_dec r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;
    assign o_full = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data = r_mem[r_rp];
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

>>> sv/adpu_back.sv
`default_nettype none
module adpu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_go,
    input  adpu_pkg::t_dec     i_dec,
    output logic               o_done,
    output adpu_pkg::t_res     o_res
);
    import adpu_pkg::*;
    logic [63:0] r_gpr [NREGS];
    logic [3:0] r_nzcv;
    logic [31:0] ins;
    logic sf;
    logic [1:0] opc;
    logic [63:0] m, a, b, op2, sv, res, ra, prod, ps;
    logic [63:0] mb, mp, r_acc;
    logic [31:0] mul_x, mul_y;
    logic [1:0] r_mstep;
    logic mul_step;
    logic [4:0] rd;
    logic [5:0] amt;
    logic [64:0] sum;
    logic [32:0] sum32;
    logic carry, setf, logf, ok;
    logic [5:0] hsh;

    function automatic logic [63:0] rdr(input logic [4:0] idx);
        rdr = (idx == ZERO_REG) ? 64'd0 : r_gpr[idx];
    endfunction

    assign ins = i_dec.ins;
    assign sf = ins[31];
    assign opc = ins[30:29];
    assign rd = ins[4:0];
    assign m = sf ? '1 : 64'h0000_0000_FFFF_FFFF;
    assign amt = ins[15:10] & (sf ? 6'd63 : 6'd31);
    assign hsh = {ins[22:21], 4'd0};

    // operand reads from the register file
    always_comb begin
        a = rdr(ins[9:5]) & m;
        mb = rdr(ins[20:16]) & m;
        ra = rdr(ins[14:10]) & m;
    end

    always_comb begin
        logic [63:0] v;
        v = rdr(ins[20:16]) & m;
        sv = v;
        if (amt != '0) begin
            case (ins[23:22])
                2'b00: sv = (v << amt) & m;
                2'b01: sv = v >> amt;
                2'b10: sv = sf ? 64'($signed(v) >>> amt)
                               : {32'd0, 32'($signed(v[31:0]) >>> amt[4:0])};
                default: sv = sf ? ((v >> amt) | (v << (7'd64 - {1'b0, amt})))
                                 : {32'd0, (v[31:0] >> amt[4:0])
                                    | (v[31:0] << (6'd32 - {1'b0, amt[4:0]}))};
            endcase
        end
    end

    assign op2 = (i_dec.kind == K_ADDI)
        ? (ins[22] ? {40'd0, ins[21:10], 12'd0} : {52'd0, ins[21:10]}) : sv;
    assign b = (opc[1] ? ~op2 : op2) & m;
    assign sum = {1'b0, a} + {1'b0, b} + 65'(opc[1]);
    assign sum32 = {1'b0, a[31:0]} + {1'b0, b[31:0]} + 33'(opc[1]);

    // low 64 product bits from one 32x32 multiplier over three steps:
    // lo*lo, then lo*hi and hi*lo folded into the upper half
    always_comb begin
        case (r_mstep)
            2'd0: begin
                mul_x = a[31:0];
                mul_y = mb[31:0];
            end
            2'd1: begin
                mul_x = a[31:0];
                mul_y = mb[63:32];
            end
            default: begin
                mul_x = a[63:32];
                mul_y = mb[31:0];
            end
        endcase
    end

    assign mp = {32'd0, mul_x} * {32'd0, mul_y};
    assign mul_step = i_valid && (i_dec.kind == K_MUL) && (r_mstep != 2'd3);
    assign o_done = (i_dec.kind != K_MUL) || (r_mstep == 2'd3);
    assign prod = r_acc & m;
    assign ps = (ins[15] ? ra - prod : ra + prod) & m;

    always_comb begin
        logic [63:0] mv, lo;
        ok = 1'b1;
        setf = 1'b0;
        logf = 1'b0;
        carry = sf ? sum[64] : sum32[32];
        mv = {48'd0, ins[20:5]} << hsh;
        lo = ins[21] ? (~sv & m) : sv;
        res = 64'd0;
        case (i_dec.kind)
            K_ADDI, K_ADDR: begin
                res = sum[63:0] & m;
                setf = opc[0];
            end
            K_MOVW: begin
                case (opc)
                    2'b00: res = ~mv & m;
                    2'b10: res = mv & m;
                    default: res = ((rdr(rd) & ~({48'd0, MOV_MASK} << hsh)) | mv) & m;
                endcase
            end
            K_MUL: res = ps;
            K_LOG: begin
                case (opc)
                    2'b00: res = a & lo;
                    2'b01: res = a | lo;
                    2'b10: res = a ^ lo;
                    default: begin
                        res = a & lo;
                        logf = 1'b1;
                    end
                endcase
            end
            default: ok = 1'b0;
        endcase
    end

    always_comb begin
        logic n, z, v;
        n = sf ? res[63] : res[31];
        z = (res == 64'd0);
        v = sf ? ((~(a[63] ^ b[63])) & (a[63] ^ res[63]))
               : ((~(a[31] ^ b[31])) & (a[31] ^ res[31]));
        o_res.status = !ok;
        o_res.wrote = ok;
        o_res.dest_index = ok ? rd : 5'd0;
        o_res.dest_value = res;
        if (setf) o_res.flags = {n, z, carry, v};
        else if (logf) o_res.flags = {n, z, 2'b00};
        else o_res.flags = r_nzcv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nzcv <= '0;
            r_mstep <= '0;
            for (int i = 0; i < NREGS; i++) r_gpr[i] <= '0;
        end else begin
            if (i_go) begin
                r_nzcv <= o_res.flags;
                if (ok && rd != ZERO_REG) r_gpr[rd] <= res;
                r_mstep <= '0;
            end else if (mul_step) begin
                r_mstep <= r_mstep + 1'b1;
                case (r_mstep)
                    2'd0: r_acc <= mp;
                    default: r_acc[63:32] <= r_acc[63:32] + mp[31:0];
                endcase
            end
        end
    end
endmodule
`default_nettype wire

>>> sv/aarch64_data_processing_unit_core.sv
`default_nettype none
// path: a request is queued, then execute writes its result into the output register
// madd/msub first accumulate their partial products at the queue head before execute
// throughput: one instruction per cycle while the output is drained; madd/msub hold the execute stage while they step
// the multiply reuses one 32x32 multiplier across its partial products for the low 64 product bits
// reset: synchronous active low; clears the queue, the output valid, the register file and nzcv
module aarch64_data_processing_unit_core #(
    parameter int unsigned QUEUE_DEPTH = adpu_pkg::QDEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    adpu_in_if.sink     i_req,
    adpu_out_if.source  o_rsp
);
    import adpu_pkg::*;

    t_dec dec_in, dec_q;
    t_res res;
    logic q_full, q_empty, go;
    logic exe_done;
    logic r_ov;
    t_res r_res;

    // front: classify the request into an operation kind
    adpu_front u_front (.i_cmd(i_req.cmd), .i_ins(i_req.instruction), .o_dec(dec_in));

    assign i_req.ready = !q_full;

    // short queue between decode and execute
    adpu_fifo #(.DEPTH(QUEUE_DEPTH)) u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_req.valid && !q_full), .i_data(dec_in), .o_full(q_full),
        .i_pop(go), .o_empty(q_empty), .o_data(dec_q)
    );

    // execute once the head is finished and the output register is free or being drained
    assign go = !q_empty && exe_done && (!r_ov || o_rsp.ready);

    adpu_back u_back (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(!q_empty), .i_go(go),
        .i_dec(dec_q), .o_done(exe_done), .o_res(res));

    always_ff @(posedge i_clk) begin
        if (go) r_res <= res;
        if (!i_rst_n) r_ov <= 1'b0;
        else if (go) r_ov <= 1'b1;
        else if (o_rsp.ready) r_ov <= 1'b0;
    end

    assign o_rsp.valid = r_ov;
    assign o_rsp.status = r_res.status;
    assign o_rsp.wrote = r_res.wrote;
    assign o_rsp.dest_index = r_res.dest_index;
    assign o_rsp.dest_value = r_res.dest_value;
    assign o_rsp.flags = r_res.flags;

`ifndef ASSERT_OFF
    a_err_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.status != o_rsp.wrote))
        else $error("error result must not report a write");
    a_go_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |-> !q_empty)
        else $error("execute with empty queue");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(r_res)))
        else $error("stalled result changed");
`endif
endmodule
`default_nettype wire
